/* rtl/lfuat_pkg.sv */
// ----------------------------------------------------------------------------
// lfuat_pkg
// Shared types and constants for the LFU address tracker.
// ----------------------------------------------------------------------------
package lfuat_pkg;

  localparam int ADDR_W     = 32;
  localparam int THR_W      = 16;
  localparam int SLOT_OUT_W = 5;
  localparam int CNT_OUT_W  = 16;
  localparam int OUT_W      = 56;  // 55 bits of fields, padded to whole bytes

  localparam logic [THR_W-1:0] THR_RESET = 16'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } lfuat_state_t;

endpackage

/* rtl/lfu_address_tracker_top.sv */
// ----------------------------------------------------------------------------
// lfu_address_tracker_top
// Least-frequently-used table of observed addresses with follow reporting.
// ----------------------------------------------------------------------------
// One address in flight: a new address is accepted only after the result of
//   the last one is loaded into the output register and the block is idle.
// Steps: one pass over the entry RAM, one entry per cycle, then the last read,
//   the write, the output load and an idle state before the next accept;
//   a stalled output word holds the block until it is taken.
// Reset (rst_n, synchronous): per-entry valid bits clear, so every entry reads
//   as address 0, count 0 at once; threshold returns to 3; no clearing pass.
module lfu_address_tracker_top
  import lfuat_pkg::*;
#(
  parameter int ENTRIES     = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  // in_tdata: [31:0] seen_address
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,
  // out_tdata: [0] was_hit, [5:1] slot_used, [21:6] slot_count,
  //            [22] follow_valid, [54:23] follow_address, [55] zero
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  // cfg_tdata: [15:0] follow_threshold
  input  logic             cfg_tvalid,
  output logic             cfg_tready,
  input  logic [THR_W-1:0] cfg_tdata
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int ENT_W = ADDR_W + COUNT_WIDTH;
  localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W:0]         SCAN_END  = (IDX_W + 1)'(ENTRIES);
  localparam logic [IDX_W:0]         RD_STEP   = (IDX_W + 1)'(1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

  lfuat_state_t state_r, state_nxt;

  logic [THR_W-1:0]  thr_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ENTRIES-1:0] valid_r;

  logic [IDX_W:0]    rd_cnt_r;
  logic              dat_vld_r;
  logic [IDX_W-1:0]  dat_idx_r;

  // scan trackers
  logic                   hit_r;
  logic [IDX_W-1:0]       hslot_r;
  logic [COUNT_WIDTH-1:0] hcnt_r;
  logic [COUNT_WIDTH-1:0] min_r;
  logic [IDX_W-1:0]       mslot_r;
  // two highest-index entries over threshold before the update
  logic                   j1v_r, j2v_r;
  logic [IDX_W-1:0]       j1idx_r, j2idx_r;
  logic [ADDR_W-1:0]      j1addr_r, j2addr_r;

  // finished result waiting for the output register
  logic                   res_hit_r;
  logic [IDX_W-1:0]       res_slot_r;
  logic [COUNT_WIDTH-1:0] res_cnt_r;
  logic                   res_fv_r;
  logic [ADDR_W-1:0]      res_faddr_r;

  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_data_r;

  logic             accept;
  logic             ram_we;
  logic             load_out;
  logic [ENT_W-1:0] ram_rdata;
  logic [ENT_W-1:0] ram_wdata;

  logic [ADDR_W-1:0]      ent_addr;
  logic [COUNT_WIDTH-1:0] ent_cnt;
  logic                   ent_over;

  logic [IDX_W-1:0]       upd_slot;
  logic [COUNT_WIDTH-1:0] upd_cnt;
  logic                   oth_v;
  logic [IDX_W-1:0]       oth_idx;
  logic [ADDR_W-1:0]      oth_addr;
  logic                   upd_over;
  logic                   upd_fv;
  logic [ADDR_W-1:0]      upd_faddr;

  logic [31:0] slot_ext;
  logic [31:0] cnt_ext;

  lfuat_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (upd_slot),
    .wdata (ram_wdata),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign accept     = in_tvalid && in_tready;
  assign cfg_tready = 1'b1;

  // never-written entries read as address 0, count 0
  assign ent_addr = valid_r[dat_idx_r] ? ram_rdata[ADDR_W-1:0] : '0;
  assign ent_cnt  = valid_r[dat_idx_r] ? ram_rdata[ADDR_W +: COUNT_WIDTH] : '0;
  assign ent_over = 32'(ent_cnt) > 32'(thr_r);

  // update: only the chosen slot changes
  always_comb begin
    upd_slot = hit_r ? hslot_r : mslot_r;
    if (hit_r) begin
      upd_cnt = (hcnt_r == COUNT_MAX) ? hcnt_r : hcnt_r + COUNT_ONE;
    end else begin
      upd_cnt = COUNT_ONE;
    end
    ram_wdata = {upd_cnt, addr_r};
    upd_over  = 32'(upd_cnt) > 32'(thr_r);

    // highest over-threshold entry other than the updated slot
    if (j1v_r && j1idx_r != upd_slot) begin
      oth_v    = 1'b1;
      oth_idx  = j1idx_r;
      oth_addr = j1addr_r;
    end else if (j2v_r && j2idx_r != upd_slot) begin
      oth_v    = 1'b1;
      oth_idx  = j2idx_r;
      oth_addr = j2addr_r;
    end else begin
      oth_v    = 1'b0;
      oth_idx  = '0;
      oth_addr = '0;
    end

    // slot address is the input address on hit and on replace alike
    if (upd_over && (!oth_v || upd_slot > oth_idx)) begin
      upd_fv    = 1'b1;
      upd_faddr = addr_r;
    end else begin
      upd_fv    = oth_v;
      upd_faddr = oth_addr;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (dat_vld_r && dat_idx_r == LAST_IDX) state_nxt = S_UPDATE;
      end
      S_UPDATE: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE:   in_tready = 1'b1;
      S_SCAN:   ;
      S_UPDATE: ram_we = 1'b1;
      S_DONE:   load_out = !out_tvalid_r || out_tready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      thr_r        <= THR_RESET;
      valid_r      <= '0;
      dat_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_tvalid && cfg_tready) thr_r <= cfg_tdata;
      if (ram_we) valid_r[upd_slot] <= 1'b1;
      dat_vld_r <= (state_r == S_SCAN) && (rd_cnt_r < SCAN_END);
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r   <= in_tdata;
      rd_cnt_r <= '0;
      hit_r    <= 1'b0;
      j1v_r    <= 1'b0;
      j2v_r    <= 1'b0;
    end else if (state_r == S_SCAN) begin
      rd_cnt_r  <= rd_cnt_r + RD_STEP;
      dat_idx_r <= rd_cnt_r[IDX_W-1:0];
      if (dat_vld_r) begin
        if (!hit_r && ent_addr == addr_r) begin
          hit_r   <= 1'b1;
          hslot_r <= dat_idx_r;
          hcnt_r  <= ent_cnt;
        end
        // strict compare keeps the lowest index on ties
        if (dat_idx_r == '0 || ent_cnt < min_r) begin
          min_r   <= ent_cnt;
          mslot_r <= dat_idx_r;
        end
        if (ent_over) begin
          j2v_r    <= j1v_r;
          j2idx_r  <= j1idx_r;
          j2addr_r <= j1addr_r;
          j1v_r    <= 1'b1;
          j1idx_r  <= dat_idx_r;
          j1addr_r <= ent_addr;
        end
      end
    end
    if (ram_we) begin
      res_hit_r   <= hit_r;
      res_slot_r  <= upd_slot;
      res_cnt_r   <= upd_cnt;
      res_fv_r    <= upd_fv;
      res_faddr_r <= upd_faddr;
    end
    if (load_out) begin
      out_data_r <= {1'b0, res_faddr_r, res_fv_r, cnt_ext[CNT_OUT_W-1:0],
                     slot_ext[SLOT_OUT_W-1:0], res_hit_r};
    end
  end

  assign slot_ext   = 32'(res_slot_r);
  assign cnt_ext    = 32'(res_cnt_r);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  a_scan_data_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dat_vld_r |-> state_r == S_SCAN)
    else $error("entry data outside scan");

  a_slot_marked_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPDATE |=> valid_r[$past(upd_slot)])
    else $error("updated slot not marked valid");

  a_miss_count_one: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && !res_hit_r) |-> res_cnt_r == COUNT_ONE)
    else $error("replaced entry count is not one");

  a_follow_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && !res_fv_r) |-> res_faddr_r == '0)
    else $error("follow address without follow valid");

endmodule

/* rtl/lfuat_ram.sv */
// ----------------------------------------------------------------------------
// lfuat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfuat_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
